FILE: hdl/sdpq_pkg.sv
package sdpq_pkg;

    localparam int CAPACITY = 32;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // action codes
    localparam logic [1:0] ACT_INSERT  = 2'd0;
    localparam logic [1:0] ACT_POP_MIN = 2'd1;
    localparam logic [1:0] ACT_POP_MAX = 2'd2;
    localparam logic [1:0] ACT_NOP     = 2'd3;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic signed [31:0] value;
        logic signed [31:0] prio;
    } t_entry;

    typedef struct packed {
        logic [1:0]         action;
        logic signed [31:0] new_value;
        logic signed [31:0] new_priority;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] removed_value;
        logic [1:0]         status;
        logic [5:0]         entry_count;
        logic               is_empty;
        logic signed [31:0] min_value;
        logic signed [31:0] min_priority;
        logic signed [31:0] max_value;
        logic signed [31:0] max_priority;
    } t_out_item;

    // command broadcast to every cell of the row
    typedef struct packed {
        logic       load;
        logic [1:0] action;
        t_entry     new_entry;
    } t_cell_cmd;

endpackage

FILE: hdl/sdpq_cell.sv
module sdpq_cell (
    input  logic               i_clk,
    input  sdpq_pkg::t_cell_cmd i_cmd,
    input  logic               i_occupied,
    input  logic               i_tail,
    input  logic               i_left_keep,
    input  sdpq_pkg::t_entry   i_left,
    input  sdpq_pkg::t_entry   i_right,
    output sdpq_pkg::t_entry   o_entry,
    output logic               o_keep,
    output sdpq_pkg::t_entry   o_back
);
    import sdpq_pkg::*;

    t_entry r_entry;
    t_entry n_entry;

    // entry stays put on insert when it sorts at or before the new one
    assign o_keep  = i_occupied && (r_entry.prio <= i_cmd.new_entry.prio);
    assign o_entry = r_entry;
    assign o_back  = i_tail ? r_entry : '0;

    // next content: hold, take new entry, shift from left or from right
    always_comb begin
        n_entry = r_entry;
        if (i_cmd.load) begin
            case (i_cmd.action)
                ACT_INSERT: begin
                    if (!o_keep) begin
                        n_entry = i_left_keep ? i_cmd.new_entry : i_left;
                    end
                end
                ACT_POP_MIN: n_entry = i_right;
                default:     n_entry = r_entry;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

FILE: hdl/sorted_double_ended_priority_queue.sv
// Sorted double-ended priority queue of CAPACITY (value, priority) entries held
// in a row of cells in ascending priority; an insert lands after every entry
// of lower or equal priority, so pop-min returns equal ones in arrival order.
// Every item gives one result: removed value, status (ok, empty, full), count,
// and the front (min) and back (max) entries, zero when empty. At the accepting
// edge all cells compare against the new priority and shift in parallel, and
// in the next cycle the back entry is picked out of the row through a one-hot
// OR select and the result is registered. No new item is accepted while one is
// pending, nor while the result waits on a stalled output; the result register
// lets the next item in while it drains.
module sorted_double_ended_priority_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  sdpq_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output sdpq_pkg::t_out_item o_out_item
);
    import sdpq_pkg::*;

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_pend;
    logic             r_out_valid;
    t_out_item        r_out;
    logic [31:0]      r_removed;
    logic [1:0]       r_status;

    logic             w_accept;
    logic             w_full;
    logic             w_empty;
    logic [31:0]      n_removed;
    logic [1:0]       n_status;
    t_cell_cmd        w_cmd;
    t_entry           w_entry [CAPACITY];
    t_entry           w_back  [CAPACITY];
    logic             w_keep  [CAPACITY];
    t_entry           w_back_sel;

    assign w_full     = (r_count == CNT_W'(CAPACITY));
    assign w_empty    = (r_count == '0);
    assign o_in_stall = !i_rst_n || r_pend || (r_out_valid && i_out_stall);
    assign w_accept   = i_in_valid && !o_in_stall;

    // back entry: only the tail cell drives its slot
    always_comb begin
        w_back_sel = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            w_back_sel = w_back_sel | w_back[k];
        end
    end

    // decode the accepted item into a cell command, status and count
    always_comb begin
        w_cmd.action           = i_in_item.action;
        w_cmd.new_entry.value  = i_in_item.new_value;
        w_cmd.new_entry.prio   = i_in_item.new_priority;
        w_cmd.load             = 1'b0;
        n_status               = ST_OK;
        n_removed              = '0;
        n_count                = r_count;
        unique case (i_in_item.action)
            ACT_INSERT: begin
                if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    w_cmd.load = w_accept;
                    n_count    = r_count + CNT_W'(1);
                end
            end
            ACT_POP_MIN: begin
                if (w_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    w_cmd.load = w_accept;
                    n_removed  = w_entry[0].value;
                    n_count    = r_count - CNT_W'(1);
                end
            end
            ACT_POP_MAX: begin
                if (w_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    w_cmd.load = w_accept;
                    n_removed  = w_back_sel.value;
                    n_count    = r_count - CNT_W'(1);
                end
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
    end

    // row of cells
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic   w_left_keep;
        t_entry w_left;
        t_entry w_right;
        if (i == 0) begin : g_first
            assign w_left_keep = 1'b1;
            assign w_left      = w_cmd.new_entry;
        end else begin : g_mid
            assign w_left_keep = w_keep[i-1];
            assign w_left      = w_entry[i-1];
        end
        if (i == CAPACITY - 1) begin : g_last
            assign w_right = w_entry[i];
        end else begin : g_inner
            assign w_right = w_entry[i+1];
        end
        sdpq_cell u_cell (
            .i_clk       (i_clk),
            .i_cmd       (w_cmd),
            .i_occupied  (CNT_W'(i) < r_count),
            .i_tail      (r_count == CNT_W'(i + 1)),
            .i_left_keep (w_left_keep),
            .i_left      (w_left),
            .i_right     (w_right),
            .o_entry     (w_entry[i]),
            .o_keep      (w_keep[i]),
            .o_back      (w_back[i])
        );
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_pend <= w_accept;
            if (w_accept) begin
                r_count <= n_count;
            end
            if (r_pend) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // pending item fields and result register
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_removed <= n_removed;
            r_status  <= n_status;
        end
        if (r_pend) begin
            r_out.removed_value <= r_removed;
            r_out.status        <= r_status;
            r_out.entry_count   <= 6'(r_count);
            r_out.is_empty      <= w_empty;
            r_out.min_value     <= w_empty ? 32'sd0 : w_entry[0].value;
            r_out.min_priority  <= w_empty ? 32'sd0 : w_entry[0].prio;
            r_out.max_value     <= w_back_sel.value;
            r_out.max_priority  <= w_back_sel.prio;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count beyond capacity");

    a_pend_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> !r_out_valid)
        else $error("result register busy while a transfer is pending");

    a_pend_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |=> r_out_valid)
        else $error("pending item did not reach the result register");

    a_full_drops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_full && i_in_item.action == ACT_INSERT) |=> $stable(r_count))
        else $error("insert on full queue changed the count");

    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status == ST_EMPTY) |-> r_out.is_empty)
        else $error("empty status on a non-empty queue");

endmodule
